/* hw/rtl/cspg_pkg.sv */
// Shared types and constants for the cascade sample point generator.
package cspg_pkg;

   localparam int CHUNK_BITS = 4;
   localparam int CHUNK      = 1 << CHUNK_BITS;
   localparam int COORD_W    = 24;
   localparam int LEVEL_W    = 4;
   localparam int SHIFT_W    = 4;
   localparam int STEP_W     = 12;
   localparam int CNT_W      = 3;
   localparam int IDX_W      = 2;
   localparam int CELL_W     = 3 * CHUNK_BITS;

   typedef struct packed {
      logic [CHUNK_BITS-1:0] off;
      logic [CHUNK_BITS-1:0] stp;
      logic [CNT_W-1:0]      cnt;
      logic [CHUNK_BITS-1:0] cidx;
   } axis_type;

   typedef struct packed {
      axis_type z;
      axis_type y;
      axis_type x;
   } desc_type;

endpackage

/* hw/rtl/cascade_sample_point_generator_core.sv */
// Top level of the cascade sample point generator.
// A request is written into the queue, and its first sample point then into the output register.
// Throughput: one sample point per cycle from the back-end point counter while rsp_pop takes
//   each point; a request yields nx*ny*nz points (1 to 64); empty requests are never queued.
// A 2-entry queue decouples the front end, so requests are taken while points stream.
// Reset clears the queue, the point counters and the output valid flag.
module cascade_sample_point_generator_core #(
   parameter int SHIFT_BASE = 1,
   parameter int LEVELS     = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [cspg_pkg::COORD_W-1:0] req_chunk_x,
   input  logic signed [cspg_pkg::COORD_W-1:0] req_chunk_y,
   input  logic signed [cspg_pkg::COORD_W-1:0] req_chunk_z,
   input  logic        [cspg_pkg::LEVEL_W-1:0] req_level,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic [cspg_pkg::CHUNK_BITS-1:0]     rsp_offset_x,
   output logic [cspg_pkg::CHUNK_BITS-1:0]     rsp_offset_y,
   output logic [cspg_pkg::CHUNK_BITS-1:0]     rsp_offset_z,
   output logic [cspg_pkg::CELL_W-1:0]         rsp_cell_index,
   output logic                                rsp_last
);
   import cspg_pkg::*;

   localparam int QDEPTH = 2;

   desc_type front_desc, head_desc;
   logic     keep, q_push, q_pop, q_empty;

   cspg_front #(
      .SHIFT_BASE(SHIFT_BASE),
      .LEVELS    (LEVELS)
   ) u_front (
      .chunk_x(req_chunk_x),
      .chunk_y(req_chunk_y),
      .chunk_z(req_chunk_z),
      .level  (req_level),
      .keep   (keep),
      .desc   (front_desc)
   );

   assign q_push = req_push && !req_full && keep;

   cspg_fifo #(
      .WIDTH($bits(desc_type)),
      .DEPTH(QDEPTH)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .wdata(front_desc),
      .pop  (q_pop),
      .rdata(head_desc),
      .full (req_full),
      .empty(q_empty)
   );

   cspg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head_desc),
      .head_valid    (!q_empty),
      .head_pop      (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_offset_z  (rsp_offset_z),
      .rsp_cell_index(rsp_cell_index),
      .rsp_last      (rsp_last)
   );

   a_bad_level_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && ((req_level == '0) ||
         ({1'b0, req_level} > (LEVEL_W+1)'(LEVELS)))) |-> !q_push)
      else $error("out-of-range level queued");

   a_pop_shows_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (!rsp_empty && rsp_last))
      else $error("queue entry retired without a last point");

   a_points_continue: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |=> !rsp_empty)
      else $error("point stream broke before last");

endmodule

/* hw/rtl/cspg_front.sv */
// Front end: level check and per-axis first center, count and cell.
module cspg_front #(
   parameter int SHIFT_BASE = 1,
   parameter int LEVELS     = 3
) (
   input  logic signed [cspg_pkg::COORD_W-1:0] chunk_x,
   input  logic signed [cspg_pkg::COORD_W-1:0] chunk_y,
   input  logic signed [cspg_pkg::COORD_W-1:0] chunk_z,
   input  logic        [cspg_pkg::LEVEL_W-1:0] level,
   output logic                                keep,
   output cspg_pkg::desc_type                  desc
);
   import cspg_pkg::*;

   function automatic axis_type axis_calc(input logic [COORD_W-1:0] chunk,
                                          input logic [SHIFT_W-1:0] s);
      logic [15:0]       base;
      logic [STEP_W-1:0] half;
      logic [STEP_W-1:0] mask;
      logic [STEP_W-1:0] off;
      logic [15:0]       first;
      axis_type          r;
      base  = {chunk[15-CHUNK_BITS:0], {CHUNK_BITS{1'b0}}};
      half  = STEP_W'(1) << (s - SHIFT_W'(1));
      mask  = (STEP_W'(1) << s) - STEP_W'(1);
      off   = (half - base[STEP_W-1:0]) & mask;
      first = base + {{(16-STEP_W){1'b0}}, off};
      r.cidx = CHUNK_BITS'(first >> s);
      r.off  = off[CHUNK_BITS-1:0];
      r.stp  = mask[CHUNK_BITS-1:0] + CHUNK_BITS'(1);
      if (off >= STEP_W'(CHUNK)) begin
         r.cnt = '0;
      end else if (s <= SHIFT_W'(CHUNK_BITS)) begin
         r.cnt = CNT_W'(CHUNK >> s);
      end else begin
         r.cnt = CNT_W'(1);
      end
      return r;
   endfunction

   logic [LEVEL_W:0]   shift_sum;
   logic [SHIFT_W-1:0] shift;
   logic               level_ok;

   assign shift_sum = {1'b0, level} + (LEVEL_W+1)'(SHIFT_BASE);
   assign shift     = shift_sum[SHIFT_W-1:0];
   assign level_ok  = (level != '0) && ({1'b0, level} <= (LEVEL_W+1)'(LEVELS));

   always_comb begin
      desc.x = axis_calc(chunk_x, shift);
      desc.y = axis_calc(chunk_y, shift);
      desc.z = axis_calc(chunk_z, shift);
      keep   = level_ok && (desc.x.cnt != '0) && (desc.y.cnt != '0) && (desc.z.cnt != '0);
   end

endmodule

/* hw/rtl/cspg_fifo.sv */
// Small register queue between the front end and the point sequencer.
module cspg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

/* hw/rtl/cspg_back.sv */
// Back end: nested z, y, x point counter feeding the output register.
module cspg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  cspg_pkg::desc_type                 head,
   input  logic                               head_valid,
   output logic                               head_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic [cspg_pkg::CHUNK_BITS-1:0]    rsp_offset_x,
   output logic [cspg_pkg::CHUNK_BITS-1:0]    rsp_offset_y,
   output logic [cspg_pkg::CHUNK_BITS-1:0]    rsp_offset_z,
   output logic [cspg_pkg::CELL_W-1:0]        rsp_cell_index,
   output logic                               rsp_last
);
   import cspg_pkg::*;

   logic                  valid_ff, valid_in;
   logic [IDX_W-1:0]      ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic [CHUNK_BITS-1:0] offx_ff, offx_in, offy_ff, offy_in, offz_ff, offz_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic                  last_ff, last_in;
   logic                  load, lx, ly, lz;
   logic [CHUNK_BITS-1:0] cx, cy, cz;

   assign load = head_valid && (!valid_ff || rsp_pop);
   assign lx   = (CNT_W'(ix_ff) + CNT_W'(1)) == head.x.cnt;
   assign ly   = (CNT_W'(iy_ff) + CNT_W'(1)) == head.y.cnt;
   assign lz   = (CNT_W'(iz_ff) + CNT_W'(1)) == head.z.cnt;
   assign cx   = head.x.cidx + CHUNK_BITS'(ix_ff);
   assign cy   = head.y.cidx + CHUNK_BITS'(iy_ff);
   assign cz   = head.z.cidx + CHUNK_BITS'(iz_ff);

   always_comb begin
      valid_in = valid_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      iz_in    = iz_ff;
      offx_in  = offx_ff;
      offy_in  = offy_ff;
      offz_in  = offz_ff;
      cell_in  = cell_ff;
      last_in  = last_ff;
      head_pop = 1'b0;
      if (rsp_pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         offx_in  = head.x.off + (CHUNK_BITS'(ix_ff) * head.x.stp);
         offy_in  = head.y.off + (CHUNK_BITS'(iy_ff) * head.y.stp);
         offz_in  = head.z.off + (CHUNK_BITS'(iz_ff) * head.z.stp);
         cell_in  = {cz, cy, cx};
         last_in  = lx && ly && lz;
         head_pop = lx && ly && lz;
         if (lx) begin
            ix_in = '0;
            if (ly) begin
               iy_in = '0;
               iz_in = lz ? '0 : iz_ff + IDX_W'(1);
            end else begin
               iy_in = iy_ff + IDX_W'(1);
            end
         end else begin
            ix_in = ix_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ix_ff    <= '0;
         iy_ff    <= '0;
         iz_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         ix_ff    <= ix_in;
         iy_ff    <= iy_in;
         iz_ff    <= iz_in;
      end
   end

   always_ff @(posedge clock) begin
      offx_ff <= offx_in;
      offy_ff <= offy_in;
      offz_ff <= offz_in;
      cell_ff <= cell_in;
      last_ff <= last_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_offset_x   = offx_ff;
   assign rsp_offset_y   = offy_ff;
   assign rsp_offset_z   = offz_ff;
   assign rsp_cell_index = cell_ff;
   assign rsp_last       = last_ff;

endmodule

/* dv/tb_cascade_sample_point_generator_core.sv */
// Self-checking testbench for the cascade sample point generator core.
module tb_cascade_sample_point_generator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cspg_pkg::*;

   localparam int SHIFT_BASE   = 1;
   localparam int LEVELS       = 3;
   localparam int CELL_MASK    = CHUNK - 1;
   localparam int MAX_POINTS   = 64;
   localparam int RANDOM_ITEMS = 83;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam realtime PERIOD  = 12ns;

   localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
   localparam logic [COORD_W-1:0] COORD_NEG = 24'hFFFFFF;

   typedef struct packed {
      logic [CHUNK_BITS-1:0] ox;
      logic [CHUNK_BITS-1:0] oy;
      logic [CHUNK_BITS-1:0] oz;
      logic [CELL_W-1:0]     cidx;
      logic                  last;
   } sample_point_type;

   // typed rows carry a hand-written answer (npts is 0 or 1), the rest use the predictor
   typedef struct {
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [COORD_W-1:0]    z;
      logic [LEVEL_W-1:0]    lvl;
      bit                    typed;
      int                    npts;
      logic [CHUNK_BITS-1:0] ox;
      logic [CHUNK_BITS-1:0] oy;
      logic [CHUNK_BITS-1:0] oz;
      logic [CELL_W-1:0]     cidx;
   } request_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic signed [COORD_W-1:0] req_chunk_x = '0;
   logic signed [COORD_W-1:0] req_chunk_y = '0;
   logic signed [COORD_W-1:0] req_chunk_z = '0;
   logic [LEVEL_W-1:0]        req_level = '0;
   logic                      rsp_pop = 1'b0;
   logic                      rsp_empty;
   logic [CHUNK_BITS-1:0]     rsp_offset_x;
   logic [CHUNK_BITS-1:0]     rsp_offset_y;
   logic [CHUNK_BITS-1:0]     rsp_offset_z;
   logic [CELL_W-1:0]         rsp_cell_index;
   logic                      rsp_last;

   sample_point_type expected_points[$];
   request_row_type  directed_rows[$];
   int               mismatches = 0;
   bit               hold_wanted = 1'b0;
   int               cycles = 0;

   cascade_sample_point_generator_core #(
      .SHIFT_BASE(SHIFT_BASE),
      .LEVELS    (LEVELS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_chunk_x   (req_chunk_x),
      .req_chunk_y   (req_chunk_y),
      .req_chunk_z   (req_chunk_z),
      .req_level     (req_level),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_offset_z  (rsp_offset_z),
      .rsp_cell_index(rsp_cell_index),
      .rsp_last      (rsp_last)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic void append_point(input sample_point_type p);
      expected_points.insert(expected_points.size(), p);
   endfunction

   // Sample points of one request, z then y then x, x fastest.
   function automatic void enumerate_sample_points(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z,
                                                   input logic [LEVEL_W-1:0] lvl);
      logic [COORD_W-1:0] coord[3];
      longint             base[3];
      longint             first[3];
      longint             cnt[3];
      longint             span, step, half, total, k, fx, fy, fz;
      int                 sh;
      sample_point_type   p;
      if (lvl < 1 || lvl > LEVELS) return;
      coord[0] = x;
      coord[1] = y;
      coord[2] = z;
      sh   = int'(lvl) + SHIFT_BASE;
      step = longint'(1) << sh;
      half = step >> 1;
      for (int a = 0; a < 3; a++) begin
         base[a]  = $signed(coord[a]) * CHUNK;
         first[a] = (((base[a] - half + step - 1) >>> sh) << sh) + half;
         span     = base[a] + CHUNK - first[a];
         cnt[a]   = (span <= 0) ? 0 : (span + step - 1) / step;
         if (cnt[a] > CHUNK) cnt[a] = CHUNK;
      end
      total = cnt[0] * cnt[1] * cnt[2];
      if (total == 0 || total > MAX_POINTS) return;
      k = 0;
      for (longint iz = 0; iz < cnt[2]; iz++) begin
         for (longint iy = 0; iy < cnt[1]; iy++) begin
            for (longint ix = 0; ix < cnt[0]; ix++) begin
               fx = first[0] + ix * step;
               fy = first[1] + iy * step;
               fz = first[2] + iz * step;
               p.ox   = CHUNK_BITS'((fx - base[0]) & CELL_MASK);
               p.oy   = CHUNK_BITS'((fy - base[1]) & CELL_MASK);
               p.oz   = CHUNK_BITS'((fz - base[2]) & CELL_MASK);
               p.cidx = {CHUNK_BITS'((fz >>> sh) & CELL_MASK),
                         CHUNK_BITS'((fy >>> sh) & CELL_MASK),
                         CHUNK_BITS'((fx >>> sh) & CELL_MASK)};
               p.last = (k == total - 1);
               append_point(p);
               k++;
            end
         end
      end
   endfunction

   function automatic void add_row(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   input logic [COORD_W-1:0] z, input logic [LEVEL_W-1:0] lvl,
                                   input bit typed, input int npts,
                                   input logic [CHUNK_BITS-1:0] ox,
                                   input logic [CHUNK_BITS-1:0] oy,
                                   input logic [CHUNK_BITS-1:0] oz,
                                   input logic [CELL_W-1:0] cidx);
      request_row_type r;
      r.x = x; r.y = y; r.z = z; r.lvl = lvl;
      r.typed = typed; r.npts = npts;
      r.ox = ox; r.oy = oy; r.oz = oz; r.cidx = cidx;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 8) return 0;
      if (r < 14) return $urandom_range(1, 3);
      if (r < 15) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      unique case ($urandom_range(0, 5))
         1: return COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
         2: return COORD_MAX;
         3: return COORD_MIN;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level();
      int r, v;
      r = $urandom_range(0, 99);
      if (r < 40) return LEVEL_W'(1);
      if (r < 70) return LEVEL_W'(2);
      if (r < 90) return LEVEL_W'(3);
      v = $urandom_range(0, 12);
      return (v == 0) ? LEVEL_W'(0) : LEVEL_W'(v + LEVELS);
   endfunction

   task automatic send_request(input request_row_type r);
      int               gap;
      sample_point_type p;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_chunk_x <= r.x;
      req_chunk_y <= r.y;
      req_chunk_z <= r.z;
      req_level   <= r.lvl;
      do @(posedge clock); while (req_full);
      if (r.typed) begin
         for (int i = 0; i < r.npts; i++) begin
            p.ox = r.ox; p.oy = r.oy; p.oz = r.oz; p.cidx = r.cidx;
            p.last = (i == r.npts - 1);
            append_point(p);
         end
      end else begin
         enumerate_sample_points(r.x, r.y, r.z, r.lvl);
      end
   endtask

   function automatic void compare_field(input string name, input logic [CELL_W-1:0] want,
                                         input logic [CELL_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      sample_point_type want;
      if (!reset && !rsp_empty && rsp_pop) begin
         if (expected_points.size() == 0) begin
            $error("sample point with no request pending: cell_index %0h", rsp_cell_index);
            mismatches++;
         end else begin
            want = expected_points.pop_front();
            compare_field("offset_x", CELL_W'(want.ox), CELL_W'(rsp_offset_x));
            compare_field("offset_y", CELL_W'(want.oy), CELL_W'(rsp_offset_y));
            compare_field("offset_z", CELL_W'(want.oz), CELL_W'(rsp_offset_z));
            compare_field("cell_index", want.cidx, rsp_cell_index);
            compare_field("last", CELL_W'(want.last), CELL_W'(rsp_last));
         end
      end
   end

   // Receiver: random pop bursts and gaps, plus one long hold-off to back up the block.
   initial begin
      bit hold_taken;
      int run, gap;
      hold_taken = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_pop <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end else begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            rsp_pop <= 1'b1;
            repeat (run) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      request_row_type r;
      int              sent;

      // coarsest level: one point at the cell center; cell wraps mod 16 on each axis
      add_row(24'd0, 24'd0, 24'd0, 4'd3, 1, 1, 4'd8, 4'd8, 4'd8, 12'h000);
      add_row(COORD_NEG, COORD_NEG, COORD_NEG, 4'd3, 1, 1, 4'd8, 4'd8, 4'd8, 12'hFFF);
      add_row(COORD_MAX, COORD_MAX, COORD_MAX, 4'd3, 1, 1, 4'd8, 4'd8, 4'd8, 12'hFFF);
      add_row(COORD_MIN, COORD_MIN, COORD_MIN, 4'd3, 1, 1, 4'd8, 4'd8, 4'd8, 12'h000);
      add_row(24'd1, 24'hFFFFFE, 24'd3, 4'd3, 1, 1, 4'd8, 4'd8, 4'd8, 12'h3E1);
      // level out of range: no points
      add_row(24'd0, 24'd0, 24'd0, 4'd0, 1, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(24'd0, 24'd0, 24'd0, 4'd4, 1, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(COORD_MAX, COORD_MIN, 24'd0, 4'd8, 1, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(COORD_MIN, COORD_MAX, COORD_NEG, 4'd15, 1, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      // finer levels around zero and at the extremes
      add_row(24'd0, 24'd0, 24'd0, 4'd1, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(24'd0, 24'd0, 24'd0, 4'd2, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(COORD_NEG, 24'd0, 24'd1, 4'd1, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(COORD_MIN, COORD_MAX, COORD_NEG, 4'd2, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(COORD_MAX, COORD_MIN, 24'd5, 4'd1, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 4'd2, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(24'hAAAAAA, 24'h555555, 24'hF0F0F0, 4'd1, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);
      add_row(24'hFFFFF9, 24'd7, 24'hFFFFF8, 4'd2, 0, 0, 4'd0, 4'd0, 4'd0, 12'h000);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      hold_wanted = 1'b1;
      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         r.x = pick_coord();
         r.y = pick_coord();
         r.z = pick_coord();
         r.lvl = pick_level();
         r.typed = 1'b0;
         r.npts = 0;
         r.ox = '0; r.oy = '0; r.oz = '0; r.cidx = '0;
         send_request(r);
      end
      req_push <= 1'b0;

      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d sample points never arrived", expected_points.size());
         mismatches++;
      end

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
